/* sv/rsvm_pkg.sv */
// Package for the register/stack virtual machine execute block.
// Holds sizes, opcode and status codes, storage types and the sequencer states.
// No dependencies.
`default_nettype none
package rsvm_pkg;

    localparam int REG_COUNT   = 16;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH   = 4096;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef logic [DATA_W-1:0]   t_word;
    typedef logic [REG_AW-1:0]   t_raddr;
    typedef logic [STACK_AW-1:0] t_saddr;
    typedef logic [STACK_AW:0]   t_sp;
    typedef logic [MEM_AW-1:0]   t_maddr;
    typedef logic [CFG_W-1:0]    t_cfg;

    localparam logic [5:0] OPC_NOP       = 6'd0;
    localparam logic [5:0] OPC_ADD       = 6'd1;
    localparam logic [5:0] OPC_SUB       = 6'd2;
    localparam logic [5:0] OPC_MUL       = 6'd3;
    localparam logic [5:0] OPC_DIV       = 6'd4;
    localparam logic [5:0] OPC_LOAD_IMM  = 6'd18;
    localparam logic [5:0] OPC_LOAD      = 6'd19;
    localparam logic [5:0] OPC_STORE     = 6'd20;
    localparam logic [5:0] OPC_PUSH      = 6'd23;
    localparam logic [5:0] OPC_POP       = 6'd24;
    localparam logic [5:0] OPC_JMP       = 6'd27;
    localparam logic [5:0] OPC_JMP_TRUE  = 6'd28;
    localparam logic [5:0] OPC_JMP_FALSE = 6'd29;
    localparam logic [5:0] OPC_MALLOC    = 6'd54;
    localparam logic [5:0] OPC_FREE      = 6'd55;
    localparam logic [5:0] OPC_PRINT     = 6'd56;
    localparam logic [5:0] OPC_HALT      = 6'd57;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_STACK   = 3'd2;
    localparam logic [2:0] ST_DIVZ    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RA, S_RB, S_RD, S_EXEC, S_MUL, S_DIV,
        S_AHEAD, S_ACHK, S_AV, S_ANX, S_AFIN, S_FREAD, S_FWR, S_DONE
    } t_state;

endpackage
`default_nettype wire

/* sv/rsvm_instr_if.sv */
// Instruction channel interface: valid/ready handshake with opcode and operand.
// No dependencies.
`default_nettype none
interface rsvm_instr_if;
    logic        valid;
    logic        ready;
    logic [5:0]  opcode;
    logic [31:0] operand;
    modport source (output valid, opcode, operand, input ready);
    modport sink   (input valid, opcode, operand, output ready);
endinterface
`default_nettype wire

/* sv/rsvm_result_if.sv */
// Result channel interface: valid/ready handshake with status and next program counter.
// No dependencies.
`default_nettype none
interface rsvm_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] next_pc;
    modport source (output valid, status, next_pc, input ready);
    modport sink   (input valid, status, next_pc, output ready);
endinterface
`default_nettype wire

/* sv/rsvm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module rsvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* sv/rsvm_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on rsvm_pkg.
`default_nettype none
module rsvm_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  rsvm_pkg::t_word   i_dividend,
    input  rsvm_pkg::t_word   i_divisor,
    output logic              o_done,
    output rsvm_pkg::t_word   o_quotient
);
    logic            r_busy;
    logic            r_done;
    logic [4:0]      r_cnt;
    rsvm_pkg::t_word r_rem;
    rsvm_pkg::t_word r_quo;
    rsvm_pkg::t_word r_div;
    logic            r_neg;
    logic [32:0]     w_trial;
    logic            w_ge;
    logic [32:0]     w_diff;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
                r_div  <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
                r_neg  <= i_dividend[31] ^ i_divisor[31];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_quo <= {r_quo[30:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule
`default_nettype wire

/* sv/register_stack_vm_execute.sv */
// Register/stack virtual machine execute block: register file, stack and data memory in RAMs.
// Operands are read in S_RA, S_RB, S_RD, then S_EXEC; MUL adds S_MUL and DIV waits in S_DIV.
// MALLOC walks the heap via S_AHEAD, S_ACHK, S_AV, S_ANX, S_AFIN; FREE: S_FREAD, S_FWR if valid.
// The next transaction is taken in the cycle after the result is registered; the divider and
// the heap walk set the long cases. After reset a clearing pass zeros data memory.
// One instruction at a time; a finished result waits in an output register.
// Depends on rsvm_pkg, rsvm_instr_if, rsvm_result_if, rsvm_ram and rsvm_div.
`default_nettype none
module register_stack_vm_execute (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rsvm_instr_if.sink                 i_instr,
    rsvm_result_if.source              o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [12:0]           i_cfg_wdata
);
    rsvm_pkg::t_state r_state, n_state;
    rsvm_pkg::t_maddr r_clr, n_clr;
    rsvm_pkg::t_cfg   r_cfg;
    rsvm_pkg::t_word  r_pc, n_pc;
    rsvm_pkg::t_sp    r_sp, n_sp;
    logic [rsvm_pkg::REG_COUNT-1:0] r_vld, n_vld;
    logic [5:0]       r_opc, n_opc;
    rsvm_pkg::t_word  r_opd, n_opd;
    rsvm_pkg::t_word  r_a, n_a, r_b, n_b, r_d, n_d, r_prod, n_prod;
    rsvm_pkg::t_word  r_v, n_v, r_block, n_block, r_npc, n_npc;
    logic [2:0]       r_st, n_st;
    rsvm_pkg::t_maddr r_curr, n_curr, r_steps, n_steps;
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_status, n_out_status;
    rsvm_pkg::t_word  r_out_pc, n_out_pc;

    logic             w_rf_we;
    rsvm_pkg::t_raddr w_rf_raddr;
    rsvm_pkg::t_word  w_rf_wdata, w_rf_rdata;
    logic             w_stk_we;
    rsvm_pkg::t_saddr w_stk_raddr;
    rsvm_pkg::t_word  w_stk_rdata;
    logic             w_mem_we;
    rsvm_pkg::t_maddr w_mem_waddr, w_mem_raddr;
    rsvm_pkg::t_word  w_mem_wdata, w_mem_rdata;
    logic             w_div_start, w_div_done;
    rsvm_pkg::t_word  w_div_q;

    rsvm_pkg::t_raddr w_ri, w_sa, w_sb;
    logic             w_dok, w_hok, w_sa_ok, w_sb_ok, w_imm_ok, w_fok, w_hit;
    logic [31:0]      w_msz, w_imm, w_idx, w_bi;
    rsvm_pkg::t_maddr w_hs, w_hu;

    rsvm_ram #(.WIDTH(rsvm_pkg::DATA_W), .DEPTH(rsvm_pkg::REG_COUNT)) u_rf (
        .i_clk(i_clk), .i_we(w_rf_we), .i_waddr(w_ri), .i_wdata(w_rf_wdata),
        .i_raddr(w_rf_raddr), .o_rdata(w_rf_rdata)
    );

    rsvm_ram #(.WIDTH(rsvm_pkg::DATA_W), .DEPTH(rsvm_pkg::STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_stk_we), .i_waddr(r_sp[rsvm_pkg::STACK_AW-1:0]),
        .i_wdata(r_d), .i_raddr(w_stk_raddr), .o_rdata(w_stk_rdata)
    );

    rsvm_ram #(.WIDTH(rsvm_pkg::DATA_W), .DEPTH(rsvm_pkg::MEM_DEPTH)) u_mem (
        .i_clk(i_clk), .i_we(w_mem_we), .i_waddr(w_mem_waddr), .i_wdata(w_mem_wdata),
        .i_raddr(w_mem_raddr), .o_rdata(w_mem_rdata)
    );

    rsvm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(r_a), .i_divisor(r_b), .o_done(w_div_done), .o_quotient(w_div_q)
    );

    assign w_ri     = r_opd[16 +: rsvm_pkg::REG_AW];
    assign w_sa     = r_opd[8 +: rsvm_pkg::REG_AW];
    assign w_sb     = r_opd[0 +: rsvm_pkg::REG_AW];
    assign w_dok    = {16'd0, r_opd[31:16]} < 32'(rsvm_pkg::REG_COUNT);
    assign w_hok    = {24'd0, r_opd[23:16]} < 32'(rsvm_pkg::REG_COUNT);
    assign w_sa_ok  = {24'd0, r_opd[15:8]} < 32'(rsvm_pkg::REG_COUNT);
    assign w_sb_ok  = {24'd0, r_opd[7:0]} < 32'(rsvm_pkg::REG_COUNT);
    assign w_imm    = {16'd0, r_opd[15:0]};
    assign w_msz    = (32'(r_cfg) < 32'(rsvm_pkg::MEM_DEPTH)) ? 32'(r_cfg)
                                                              : 32'(rsvm_pkg::MEM_DEPTH);
    assign w_imm_ok = w_imm < w_msz;
    assign w_hs     = rsvm_pkg::t_maddr'((w_msz * 32'd3) >> 2);
    assign w_hu     = rsvm_pkg::t_maddr'(w_msz >> 2);
    assign w_idx    = {2'b00, r_d[31:2]};
    assign w_fok    = (r_d != '0) && (w_idx > 32'(w_hs) + 32'd2)
                      && (w_idx < 32'(w_hs) + 32'(w_hu));
    assign w_bi     = w_idx - 32'(w_hs) - 32'd2;
    assign w_hit    = (r_v == '0) || (!r_v[31] && (r_v >= r_block));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pc         = r_pc;
        n_sp         = r_sp;
        n_vld        = r_vld;
        n_opc        = r_opc;
        n_opd        = r_opd;
        n_a          = r_a;
        n_b          = r_b;
        n_d          = r_d;
        n_prod       = r_prod;
        n_v          = r_v;
        n_block      = r_block;
        n_npc        = r_npc;
        n_st         = r_st;
        n_curr       = r_curr;
        n_steps      = r_steps;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_status = r_out_status;
        n_out_pc     = r_out_pc;
        w_rf_we      = 1'b0;
        w_rf_wdata   = '0;
        w_rf_raddr   = w_sa;
        w_stk_we     = 1'b0;
        w_stk_raddr  = rsvm_pkg::t_saddr'(r_sp - 1'b1);
        w_mem_we     = 1'b0;
        w_mem_waddr  = '0;
        w_mem_wdata  = '0;
        w_mem_raddr  = rsvm_pkg::t_maddr'(r_opd);
        w_div_start  = 1'b0;
        i_instr.ready = 1'b0;

        unique case (r_state)
            rsvm_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = rsvm_pkg::S_IDLE;
                end
            end
            rsvm_pkg::S_IDLE: begin
                i_instr.ready = 1'b1;
                w_rf_raddr    = i_instr.operand[8 +: rsvm_pkg::REG_AW];
                if (i_instr.valid) begin
                    n_opc   = i_instr.opcode;
                    n_opd   = i_instr.operand;
                    n_state = rsvm_pkg::S_RA;
                end
            end
            rsvm_pkg::S_RA: begin
                n_a        = (w_sa_ok && r_vld[w_sa]) ? w_rf_rdata : '0;
                w_rf_raddr = w_sb;
                n_state    = rsvm_pkg::S_RB;
            end
            rsvm_pkg::S_RB: begin
                n_b        = (w_sb_ok && r_vld[w_sb]) ? w_rf_rdata : '0;
                w_rf_raddr = w_ri;
                n_state    = rsvm_pkg::S_RD;
            end
            rsvm_pkg::S_RD: begin
                n_d     = r_vld[w_ri] ? w_rf_rdata : '0;
                n_state = rsvm_pkg::S_EXEC;
            end
            rsvm_pkg::S_EXEC: begin
                n_st    = rsvm_pkg::ST_OK;
                n_npc   = r_pc + 32'd1;
                n_state = rsvm_pkg::S_DONE;
                if (32'(r_sp) >= 32'(rsvm_pkg::STACK_DEPTH)) begin
                    n_st  = rsvm_pkg::ST_STACK;
                    n_npc = r_pc;
                end else begin
                    unique case (r_opc)
                        rsvm_pkg::OPC_NOP, rsvm_pkg::OPC_PRINT: begin
                        end
                        rsvm_pkg::OPC_LOAD_IMM: begin
                            w_rf_we    = w_dok;
                            w_rf_wdata = w_imm;
                        end
                        rsvm_pkg::OPC_ADD: begin
                            w_rf_we    = w_dok;
                            w_rf_wdata = r_a + r_b;
                        end
                        rsvm_pkg::OPC_SUB: begin
                            w_rf_we    = w_dok;
                            w_rf_wdata = r_a - r_b;
                        end
                        rsvm_pkg::OPC_MUL: begin
                            n_prod  = r_a * r_b;
                            n_state = rsvm_pkg::S_MUL;
                        end
                        rsvm_pkg::OPC_DIV: begin
                            if (r_b == '0) begin
                                n_st  = rsvm_pkg::ST_DIVZ;
                                n_npc = r_pc;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = rsvm_pkg::S_DIV;
                            end
                        end
                        rsvm_pkg::OPC_LOAD: begin
                            w_rf_we    = w_dok && w_imm_ok;
                            w_rf_wdata = w_mem_rdata;
                        end
                        rsvm_pkg::OPC_STORE: begin
                            w_mem_we    = w_dok && w_imm_ok;
                            w_mem_waddr = rsvm_pkg::t_maddr'(r_opd);
                            w_mem_wdata = r_d;
                        end
                        rsvm_pkg::OPC_JMP: begin
                            n_npc = r_opd;
                        end
                        rsvm_pkg::OPC_JMP_TRUE: begin
                            if (w_dok && (r_d != '0)) begin
                                n_npc = w_imm;
                            end
                        end
                        rsvm_pkg::OPC_JMP_FALSE: begin
                            if (w_dok && (r_d == '0)) begin
                                n_npc = w_imm;
                            end
                        end
                        rsvm_pkg::OPC_PUSH: begin
                            if (w_dok) begin
                                w_stk_we = 1'b1;
                                n_sp     = r_sp + 1'b1;
                            end
                        end
                        rsvm_pkg::OPC_POP: begin
                            if (r_sp == '0) begin
                                n_st  = rsvm_pkg::ST_STACK;
                                n_npc = r_pc;
                            end else if (w_dok) begin
                                n_sp       = r_sp - 1'b1;
                                w_rf_we    = 1'b1;
                                w_rf_wdata = w_stk_rdata;
                            end
                        end
                        rsvm_pkg::OPC_MALLOC: begin
                            if (w_hok && w_sa_ok) begin
                                w_mem_raddr = w_hs;
                                n_block = 32'(((33'(r_a) + 33'd3) >> 2) + 33'd2);
                                n_state = rsvm_pkg::S_AHEAD;
                            end
                        end
                        rsvm_pkg::OPC_FREE: begin
                            if (w_hok) begin
                                w_mem_raddr = w_hs;
                                n_state     = rsvm_pkg::S_FREAD;
                            end
                        end
                        rsvm_pkg::OPC_HALT: begin
                            n_st  = rsvm_pkg::ST_HALT;
                            n_npc = r_pc;
                        end
                        default: begin
                            n_st  = rsvm_pkg::ST_UNKNOWN;
                            n_npc = r_pc;
                        end
                    endcase
                end
            end
            rsvm_pkg::S_MUL: begin
                w_rf_we    = w_dok;
                w_rf_wdata = r_prod;
                n_state    = rsvm_pkg::S_DONE;
            end
            rsvm_pkg::S_DIV: begin
                if (w_div_done) begin
                    w_rf_we    = w_dok;
                    w_rf_wdata = w_div_q;
                    n_state    = rsvm_pkg::S_DONE;
                end
            end
            rsvm_pkg::S_AHEAD: begin
                if (33'(w_hu) >= 33'(r_block) + 33'd1) begin
                    n_curr  = ((w_mem_rdata != '0) && (w_mem_rdata < 32'(w_hu)))
                              ? rsvm_pkg::t_maddr'(w_mem_rdata) : rsvm_pkg::t_maddr'(1);
                    n_steps = '0;
                    n_state = rsvm_pkg::S_ACHK;
                end else begin
                    w_rf_we = 1'b1;
                    n_state = rsvm_pkg::S_DONE;
                end
            end
            rsvm_pkg::S_ACHK: begin
                if ((33'(r_curr) + 33'(r_block) < 33'(w_hu)) && (r_steps < w_hu)) begin
                    w_mem_raddr = w_hs + r_curr;
                    n_state     = rsvm_pkg::S_AV;
                end else begin
                    w_rf_we = 1'b1;
                    n_state = rsvm_pkg::S_DONE;
                end
            end
            rsvm_pkg::S_AV: begin
                n_v         = w_mem_rdata;
                w_mem_raddr = w_hs + r_curr + 1'b1;
                n_state     = rsvm_pkg::S_ANX;
            end
            rsvm_pkg::S_ANX: begin
                if (w_hit) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_hs + r_curr;
                    w_mem_wdata = r_block;
                    n_state     = rsvm_pkg::S_AFIN;
                end else begin
                    if (!w_mem_rdata[31] && (w_mem_rdata < 32'(w_hu))) begin
                        n_curr = rsvm_pkg::t_maddr'(w_mem_rdata);
                    end else begin
                        n_curr = rsvm_pkg::t_maddr'(32'(r_curr) + r_block);
                    end
                    n_steps = r_steps + 1'b1;
                    n_state = rsvm_pkg::S_ACHK;
                end
            end
            rsvm_pkg::S_AFIN: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_hs + r_curr + 1'b1;
                w_mem_wdata = '1;
                w_rf_we     = 1'b1;
                w_rf_wdata  = (32'(w_hs) + 32'(r_curr) + 32'd2) << 2;
                n_state     = rsvm_pkg::S_DONE;
            end
            rsvm_pkg::S_FREAD: begin
                n_state = rsvm_pkg::S_DONE;
                if (w_fok) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_hs;
                    w_mem_wdata = w_bi;
                    n_v         = w_mem_rdata;
                    n_state     = rsvm_pkg::S_FWR;
                end
            end
            rsvm_pkg::S_FWR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = rsvm_pkg::t_maddr'(w_idx - 32'd1);
                w_mem_wdata = r_v;
                n_state     = rsvm_pkg::S_DONE;
            end
            rsvm_pkg::S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_st;
                    n_out_pc     = r_npc;
                    n_pc         = r_npc;
                    n_state      = rsvm_pkg::S_IDLE;
                end
            end
        endcase

        if (w_rf_we) begin
            n_vld[w_ri] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsvm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_cfg       <= rsvm_pkg::CFG_RESET;
            r_pc        <= '0;
            r_sp        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_sp        <= n_sp;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opc        <= n_opc;
        r_opd        <= n_opd;
        r_a          <= n_a;
        r_b          <= n_b;
        r_d          <= n_d;
        r_prod       <= n_prod;
        r_v          <= n_v;
        r_block      <= n_block;
        r_npc        <= n_npc;
        r_st         <= n_st;
        r_curr       <= n_curr;
        r_steps      <= n_steps;
        r_out_status <= n_out_status;
        r_out_pc     <= n_out_pc;
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.status  = r_out_status;
    assign o_result.next_pc = r_out_pc;
endmodule
`default_nettype wire
